@@ rtl/assert_macros.svh @@
// Assertion shorthand for the edge filter RTL.
// Needs a clock named clk and an active-low reset named rst_n where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the condition holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

@@ rtl/rgse_pkg.sv @@
// Shared types and constants of the RGB-to-gray Sobel edge filter.
// No dependencies; used by every module of the block.
package rgse_pkg;

  // Configuration register layout.
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int MIN_DIM      = 3;

  // Request kinds on the op field.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Q16 luma weights; they sum to 65536 so gray stays within 8 bits.
  localparam logic [13:0] WEIGHT_RED   = 14'd13933;
  localparam logic [15:0] WEIGHT_GREEN = 16'd46871;
  localparam logic [12:0] WEIGHT_BLUE  = 13'd4732;

  localparam logic [7:0] EDGE_MAX = 8'd255;

  // Output queue geometry.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  // Decisions taken for one request when it is accepted.
  typedef struct packed {
    logic update;     // request falls inside the frame: shift window, write stores
    logic flush;      // no color: gray is zero
    logic emit;       // request produces a result
    logic border;     // result pixel lies on the image border
    logic last;       // result pixel is the last one of the frame
  } item_ctrl_t;

  typedef struct packed {
    logic [7:0] edge_value;
    logic       frame_end;
  } result_t;

endpackage

@@ rtl/rgse_ctrl.sv @@
// Frame counters and configuration registers of the edge filter.
// Depends on rgse_pkg.
module rgse_ctrl import rgse_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int WW    = $clog2(MAX_WIDTH + 1),
  localparam int HH    = $clog2(MAX_HEIGHT + 1),
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic                  op,
  output item_ctrl_t            item,
  output logic [COL_W-1:0]      col
);

  localparam int W_RST = (RESET_WIDTH  > MAX_WIDTH)  ? MAX_WIDTH  : RESET_WIDTH;
  localparam int H_RST = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  logic [WW-1:0]    w_r;
  logic [HH-1:0]    h_r;
  logic [COL_W-1:0] in_col_r;
  logic [ROW_W-1:0] in_row_r;
  logic [COL_W-1:0] out_col_r;
  logic [HH-1:0]    out_row_r;

  logic [31:0]   w_req, h_req;
  logic [WW-1:0] w_clamped;
  logic [HH-1:0] h_clamped;
  logic [WW-1:0] wm1, col_inc, out_col_inc;
  logic [HH-1:0] hm1;
  logic          col_wrap, out_wrap;

  assign w_req = 32'(cfg_data[WIDTH_REG_W-1:0]);
  assign h_req = 32'(cfg_data[HEIGHT_REG_W-1:0]);

  always_comb begin
    priority if (w_req < 32'(MIN_DIM)) w_clamped = WW'(MIN_DIM);
    else if (w_req > 32'(MAX_WIDTH))   w_clamped = WW'(MAX_WIDTH);
    else                               w_clamped = WW'(w_req);
    priority if (h_req < 32'(MIN_DIM)) h_clamped = HH'(MIN_DIM);
    else if (h_req > 32'(MAX_HEIGHT))  h_clamped = HH'(MAX_HEIGHT);
    else                               h_clamped = HH'(h_req);
  end

  assign wm1         = w_r - 1'b1;
  assign hm1         = h_r - 1'b1;
  assign col_inc     = WW'(in_col_r) + 1'b1;
  assign col_wrap    = col_inc >= w_r;
  assign out_col_inc = WW'(out_col_r) + 1'b1;
  assign out_wrap    = out_col_inc >= w_r;
  assign col         = in_col_r;

  always_comb begin
    item.update = in_row_r < ROW_W'(h_r);
    item.flush  = (op == OP_FLUSH);
    item.emit   = (in_row_r >= ROW_W'(2)) || ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
    item.last   = (out_row_r >= hm1) && (WW'(out_col_r) >= wm1);
    item.border = (out_row_r == '0) || (out_col_r == '0) ||
                  (out_row_r >= hm1) || (WW'(out_col_r) >= wm1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= WW'(W_RST);
      h_r       <= HH'(H_RST);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_IMAGE_WIDTH)  w_r <= w_clamped;
      if (cfg_index == REG_IMAGE_HEIGHT) h_r <= h_clamped;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (accept) begin
      if (item.emit && item.last) begin
        // Frame done: the next request starts a new frame.
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else begin
        in_col_r <= col_wrap ? '0 : COL_W'(col_inc);
        in_row_r <= in_row_r + ROW_W'(col_wrap);
        if (item.emit) begin
          out_col_r <= out_wrap ? '0 : COL_W'(out_col_inc);
          out_row_r <= out_row_r + HH'(out_wrap);
        end
      end
    end
  end

endmodule

@@ rtl/rgse_window.sv @@
// Gray conversion, two line stores, 3x3 window and Sobel magnitude.
// Depends on rgse_pkg.
module rgse_window import rgse_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             accept,
  input  item_ctrl_t       item,
  input  logic [COL_W-1:0] col,
  input  logic [7:0]       red,
  input  logic [7:0]       green,
  input  logic [7:0]       blue,
  output logic             push,
  output result_t          result
);

  logic [7:0] older_mem [MAX_WIDTH];
  logic [7:0] newer_mem [MAX_WIDTH];

  logic [7:0]       up2_r, up1_r;
  logic [21:0]      red_prod_r;
  logic [23:0]      green_prod_r;
  logic [20:0]      blue_prod_r;
  logic             s1_valid_r;
  item_ctrl_t       s1_ctrl_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s2_valid_r;
  logic             s2_border_r;
  logic             s2_last_r;
  logic [7:0]       win_r [9];

  logic [23:0] luma_sum;
  logic [7:0]  gray;
  logic [9:0]  gx_pos, gx_neg, gy_pos, gy_neg, gx_abs, gy_abs;
  logic [10:0] mag;

  // Stage 1: read both stores at the request's column, form weighted products.
  always_ff @(posedge clk) begin
    if (accept) begin
      up2_r        <= older_mem[col];
      up1_r        <= newer_mem[col];
      red_prod_r   <= item.flush ? '0 : 22'(red)   * 22'(WEIGHT_RED);
      green_prod_r <= item.flush ? '0 : 24'(green) * 24'(WEIGHT_GREEN);
      blue_prod_r  <= item.flush ? '0 : 21'(blue)  * 21'(WEIGHT_BLUE);
      s1_ctrl_r    <= item;
      s1_col_r     <= col;
    end
  end

  assign luma_sum = 24'(red_prod_r) + green_prod_r + 24'(blue_prod_r);
  assign gray     = luma_sum[23:16];

  // Write back: a column comes round again no sooner than three requests later,
  // so the write always lands before the next read of the same entry.
  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_ctrl_r.update) begin
      older_mem[s1_col_r] <= up1_r;
      newer_mem[s1_col_r] <= gray;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      s1_valid_r <= accept && !clear;
      s2_valid_r <= s1_valid_r && s1_ctrl_r.emit && !clear;
      priority if (clear) begin
        for (int i = 0; i < 9; i++) win_r[i] <= '0;
      end else if (s1_valid_r && s1_ctrl_r.update) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r*3]   <= win_r[r*3+1];
          win_r[r*3+1] <= win_r[r*3+2];
        end
        win_r[2] <= up2_r;
        win_r[5] <= up1_r;
        win_r[8] <= gray;
      end else if (s1_valid_r && s1_ctrl_r.last) begin
        for (int i = 0; i < 9; i++) win_r[i] <= '0;
      end else begin
        win_r <= win_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_border_r <= s1_ctrl_r.border;
      s2_last_r   <= s1_ctrl_r.last;
    end
  end

  // Stage 2: Sobel magnitude of the window.
  always_comb begin
    gx_pos = 10'(win_r[2]) + {1'b0, win_r[5], 1'b0} + 10'(win_r[8]);
    gx_neg = 10'(win_r[0]) + {1'b0, win_r[3], 1'b0} + 10'(win_r[6]);
    gy_pos = 10'(win_r[6]) + {1'b0, win_r[7], 1'b0} + 10'(win_r[8]);
    gy_neg = 10'(win_r[0]) + {1'b0, win_r[1], 1'b0} + 10'(win_r[2]);
    gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
    gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
    mag    = 11'(gx_abs) + 11'(gy_abs);
  end

  assign push              = s2_valid_r;
  assign result.frame_end  = s2_last_r;
  assign result.edge_value = s2_border_r ? '0 :
                             (mag > 11'(EDGE_MAX)) ? EDGE_MAX : mag[7:0];

endmodule

@@ rtl/rgse_out_fifo.sv @@
// Result queue with credit count that throttles the input side.
// Depends on rgse_pkg and assert_macros.svh.
module rgse_out_fifo import rgse_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    claim,
  input  logic    push,
  input  result_t result,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_result
);

  `include "assert_macros.svh"

  result_t              fifo_mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0] cnt_r;
  logic [OUT_CNT_W-1:0] credit_r;
  logic                 pop;

  assign out_valid  = cnt_r != '0;
  assign pop        = out_valid && !out_stall;
  assign out_result = fifo_mem[rd_ptr_r];
  // Every accepted request that yields a result holds one slot until taken.
  assign in_stall   = credit_r == OUT_CNT_W'(OUT_DEPTH);

  always_ff @(posedge clk) begin
    if (push) fifo_mem[wr_ptr_r] <= result;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      credit_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r    <= cnt_r + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
      credit_r <= credit_r + OUT_CNT_W'(claim) - OUT_CNT_W'(pop);
    end
  end

  `ASSERT_ALWAYS(a_cnt_within_credit, cnt_r <= credit_r, "queue holds more than reserved")
  `ASSERT_ALWAYS(a_credit_bound, credit_r <= OUT_CNT_W'(OUT_DEPTH), "credit count overflow")
  `ASSERT_NEXT(a_no_claim_when_full, in_stall, credit_r <= $past(credit_r), "claim while full")
  `ASSERT_NEXT(a_pop_drains, pop && !push, cnt_r == $past(cnt_r) - 1'b1, "pop lost")

endmodule

@@ rtl/rgb_gray_sobel_edge_filter.sv @@
// Top level of the RGB-to-gray Sobel edge filter.
// Depends on rgse_pkg, rgse_ctrl, rgse_window and rgse_out_fifo.
//
//   channel | ports                                      | moves
//   --------+--------------------------------------------+-----------------------------
//   in      | in_valid in_stall in_op in_red/green/blue  | one pixel or flush request
//   out     | out_valid out_stall out_edge_value/frame_end | one edge result
//   cfg     | cfg_we cfg_index cfg_data                  | register write, no read-back
//
// One request per clock is sustained while the output is not stalled; a result is
// registered in stage 1, stage 2 and the result queue before out_valid rises,
// and output lags input by width+1 requests as a whole.
// The line store read at acceptance and its write-back in the cycle after set the
// pipeline; the four-entry result queue covers the credit loop and keeps it at full rate.
// rst_n is synchronous and active low; the line stores are not cleared.
// A stall on the output lets requests reserve all slots of the four-entry result queue, after which
// in_stall rises (driven from registers only) until a result is taken.
module rgb_gray_sobel_edge_filter import rgse_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_edge_value,
  output logic                  out_frame_end
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  item_ctrl_t       item;
  logic [COL_W-1:0] col;
  logic             accept;
  logic             push;
  result_t          result;
  result_t          out_result;

  // A request is taken when valid and not stalled; config writes must only
  // arrive while the block is idle, which the block itself does not enforce.
  assign accept = in_valid && !in_stall;

  rgse_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .op        (in_op),
    .item      (item),
    .col       (col)
  );

  // The window stage reads both line stores at the current column and
  // produces one Sobel result per emitting request.
  rgse_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (cfg_we),
    .accept (accept),
    .item   (item),
    .col    (col),
    .red    (in_red),
    .green  (in_green),
    .blue   (in_blue),
    .push   (push),
    .result (result)
  );

  // A slot is reserved at acceptance for every request that yields a result,
  // so the queue never overflows while the pipeline runs unstalled.
  rgse_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .claim      (accept && item.emit),
    .push       (push),
    .result     (result),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_edge_value = out_result.edge_value;
  assign out_frame_end  = out_result.frame_end;

endmodule
